// ----- rtl/dbrs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the dual-bank refresh scheduler.
// No dependencies; every other file of the block imports this package.
package dbrs_pkg;

    // Field widths of the streaming channels.
    localparam int NOW_W      = 48;
    localparam int OPEN_W     = 16;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 8;
    localparam int INTERVAL_W = 16;
    localparam int CFG_DATA_W = 16;

    // Depth of the slot queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic CFG_REDUCED_BANK  = 1'b0;
    localparam logic CFG_SLOT_INTERVAL = 1'b1;

    // Command kinds on the result channel.
    typedef enum logic {
        CMD_PRECHARGE = 1'b0,
        CMD_REFRESH   = 1'b1
    } cmd_kind_t;

    // One refresh slot as classified by the front part.
    typedef struct packed {
        logic       pair;     // 0: groups 0 and 1, 1: groups 2 and 3
        logic [1:0] bank;     // bank address within the groups
        logic       open_lo;  // bank is open in the first group of the pair
        logic       open_hi;  // bank is open in the second group of the pair
    } slot_rec_t;

endpackage

// ----- rtl/dbrs_front.sv -----
`timescale 1ns / 1ps
// Front part: accepts controller cycles, tracks due time and round-robin state,
// and pushes one slot record per refreshed slot. Depends on dbrs_pkg.
module dbrs_front #(
    parameter int BANK_COUNT      = 4,
    parameter int REDUCED_DIVISOR = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_addr,
    input  logic [dbrs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dbrs_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                                push,
    output dbrs_pkg::slot_rec_t                 push_rec,
    input  logic                                q_full
);
    import dbrs_pkg::*;

    localparam int BA_W   = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
    localparam int TURN_W = (REDUCED_DIVISOR > 1) ? $clog2(REDUCED_DIVISOR) : 1;
    localparam logic [BA_W-1:0]   BA_LAST   = BA_W'(BANK_COUNT - 1);
    localparam logic [TURN_W-1:0] TURN_LAST = TURN_W'(REDUCED_DIVISOR - 1);

    logic [1:0]            reduced_bank_reg,  reduced_bank_next;
    logic [INTERVAL_W-1:0] slot_interval_reg, slot_interval_next;
    logic [NOW_W-1:0]      next_due_reg,      next_due_next;
    logic [BA_W-1:0]       next_bank_reg,     next_bank_next;
    logic [TURN_W-1:0]     reduced_turn_reg,  reduced_turn_next;
    logic [3:0]            pair_sel_reg,      pair_sel_next;

    logic [NOW_W-1:0]      now;
    logic [OPEN_W-1:0]     bank_open;
    logic [INTERVAL_W-1:0] wr_interval;
    logic                  accept;
    logic                  slot;
    logic                  is_reduced;
    logic                  issue;
    logic [1:0]            b2;
    logic                  pair;

    assign now       = s_tdata[NOW_W-1:0];
    assign bank_open = s_tdata[NOW_W+OPEN_W-1:NOW_W];
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    // Slot detection and reduced-rate decision.
    assign slot       = accept && (now >= next_due_reg);
    assign is_reduced = (4'(next_bank_reg) == {2'b00, reduced_bank_reg});
    assign issue      = !is_reduced || (reduced_turn_reg == '0);
    assign b2         = 2'(next_bank_reg);
    assign pair       = pair_sel_reg[b2];
    assign wr_interval = (cfg_wdata == '0) ? INTERVAL_W'(1) : cfg_wdata;

    // Slot record toward the queue.
    assign push             = slot && issue;
    assign push_rec.pair    = pair;
    assign push_rec.bank    = b2;
    assign push_rec.open_lo = bank_open[{pair, 1'b0, b2}];
    assign push_rec.open_hi = bank_open[{pair, 1'b1, b2}];

    // Next-state logic; configuration writes must arrive only while idle, which the block does not enforce.
    always_comb
    begin
        reduced_bank_next  = reduced_bank_reg;
        slot_interval_next = slot_interval_reg;
        next_due_next      = next_due_reg;
        next_bank_next     = next_bank_reg;
        reduced_turn_next  = reduced_turn_reg;
        pair_sel_next      = pair_sel_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_REDUCED_BANK:
                begin
                    reduced_bank_next = cfg_wdata[1:0];
                end
                CFG_SLOT_INTERVAL:
                begin
                    slot_interval_next = wr_interval;
                    next_due_next      = NOW_W'(wr_interval);
                end
                default:
                begin
                    reduced_bank_next = reduced_bank_reg;
                end
            endcase
        end
        else if (slot)
        begin
            next_due_next  = next_due_reg + NOW_W'(slot_interval_reg);
            next_bank_next = (next_bank_reg == BA_LAST) ? '0 : next_bank_reg + 1'b1;
            if (is_reduced)
            begin
                reduced_turn_next = (reduced_turn_reg == TURN_LAST) ? '0
                                                                    : reduced_turn_reg + 1'b1;
            end
            if (issue)
            begin
                pair_sel_next[b2] = !pair_sel_reg[b2];
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reduced_bank_reg  <= '0;
            slot_interval_reg <= INTERVAL_W'(1);
            next_due_reg      <= NOW_W'(1);
            next_bank_reg     <= '0;
            reduced_turn_reg  <= '0;
            pair_sel_reg      <= '0;
        end
        else
        begin
            reduced_bank_reg  <= reduced_bank_next;
            slot_interval_reg <= slot_interval_next;
            next_due_reg      <= next_due_next;
            next_bank_reg     <= next_bank_next;
            reduced_turn_reg  <= reduced_turn_next;
            pair_sel_reg      <= pair_sel_next;
        end
    end

`ifndef SYNTHESIS
    // A slot record is only produced by an accepted beat.
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (s_tvalid && s_tready))
        else $error("slot pushed without an accepted beat");

    // The due time moves only on a served slot or an interval write.
    a_due_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (!slot && !cfg_we) |=> $stable(next_due_reg))
        else $error("due time moved without a slot");

    // Each issued slot flips exactly one pair selector.
    a_pair_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !cfg_we) |=> ($countones(pair_sel_reg ^ $past(pair_sel_reg)) == 1))
        else $error("pair selector did not flip on an issued slot");
`endif

endmodule

// ----- rtl/dbrs_fifo.sv -----
`timescale 1ns / 1ps
// Short slot queue between the front and back parts of the refresh scheduler.
// Depends on dbrs_pkg for the record type and the depth.
module dbrs_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dbrs_pkg::slot_rec_t  push_rec,
    output logic                 full,
    input  logic                 pop,
    output dbrs_pkg::slot_rec_t  pop_rec,
    output logic                 empty
);
    import dbrs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    slot_rec_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

`ifndef SYNTHESIS
    // The fill count never exceeds the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // Writers must respect the full flag; a dropped slot is lost.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

    // Count and pointers agree.
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (PTR_W'(wr_ptr_reg - rd_ptr_reg) == PTR_W'(count_reg)))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ----- rtl/dbrs_back.sv -----
`timescale 1ns / 1ps
// Back part: expands each slot record into precharge beats and a refresh beat.
// Depends on dbrs_pkg for the record type and command kinds.
module dbrs_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  dbrs_pkg::slot_rec_t             q_rec,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dbrs_pkg::M_DATA_W-1:0]   m_tdata,  // bank_group, bank, partner_group, pad
    output logic                            m_tlast,
    output logic                            m_tuser   // cmd_kind
);
    import dbrs_pkg::*;

    slot_rec_t rec_reg,     rec_next;
    logic      lo_pend_reg, lo_pend_next;
    logic      hi_pend_reg, hi_pend_next;
    logic      busy_reg,    busy_next;

    logic      beat_done;
    logic      ref_beat;
    logic      load;
    cmd_kind_t kind;
    logic [1:0] group;
    logic [1:0] partner;

    assign ref_beat  = !lo_pend_reg && !hi_pend_reg;
    assign beat_done = busy_reg && m_tready;
    assign load      = !q_empty && (!busy_reg || (beat_done && ref_beat));
    assign pop       = load;

    // Beat contents from the working record.
    always_comb
    begin
        priority if (lo_pend_reg)
        begin
            kind    = CMD_PRECHARGE;
            group   = {rec_reg.pair, 1'b0};
            partner = 2'b00;
        end
        else if (hi_pend_reg)
        begin
            kind    = CMD_PRECHARGE;
            group   = {rec_reg.pair, 1'b1};
            partner = 2'b00;
        end
        else
        begin
            kind    = CMD_REFRESH;
            group   = {rec_reg.pair, 1'b0};
            partner = {rec_reg.pair, 1'b1};
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tuser  = kind;
    assign m_tlast  = ref_beat;
    assign m_tdata  = {2'b00, partner, rec_reg.bank, group};

    // Sequencing of the beats of one run.
    always_comb
    begin
        rec_next     = rec_reg;
        lo_pend_next = lo_pend_reg;
        hi_pend_next = hi_pend_reg;
        busy_next    = busy_reg;
        if (load)
        begin
            rec_next     = q_rec;
            lo_pend_next = q_rec.open_lo;
            hi_pend_next = q_rec.open_hi;
            busy_next    = 1'b1;
        end
        else if (beat_done)
        begin
            priority if (lo_pend_reg)
            begin
                lo_pend_next = 1'b0;
            end
            else if (hi_pend_reg)
            begin
                hi_pend_next = 1'b0;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_pend_reg <= 1'b0;
            hi_pend_reg <= 1'b0;
            busy_reg    <= 1'b0;
        end
        else
        begin
            lo_pend_reg <= lo_pend_next;
            hi_pend_reg <= hi_pend_next;
            busy_reg    <= busy_next;
        end
    end

    // Record payload needs no reset.
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

`ifndef SYNTHESIS
    // Pending precharges exist only inside an active run.
    a_pend_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (!lo_pend_reg && !hi_pend_reg))
        else $error("pending precharge outside a run");

    // A run does not end before its refresh beat.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_done && !ref_beat) |=> busy_reg)
        else $error("run ended on a precharge beat");

    // A popped record always starts a run.
    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> busy_reg)
        else $error("popped record was not loaded");
`endif

endmodule

// ----- rtl/dual_bank_refresh_scheduler.sv -----
`timescale 1ns / 1ps
// Dual-bank refresh scheduler: one input beat per controller cycle, a 4-entry
// slot queue, and a run of one to three command beats per refreshed slot.
// Throughput: one input beat per cycle while the slot queue has room; one output beat per cycle
// while m_tready is high and records wait; records go via the queue into the working record.
// Reset (rst_n, asynchronous, active low) empties the queue, sets slot_interval and the
// due time to 1, reduced_bank to 0 and clears the round-robin, turn and pair state.
module dual_bank_refresh_scheduler #(
    parameter int BANK_COUNT      = 4,
    parameter int REDUCED_DIVISOR = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_addr,
    input  logic [dbrs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dbrs_pkg::S_DATA_W-1:0]       s_tdata,   // now[47:0], bank_open[63:48]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dbrs_pkg::M_DATA_W-1:0]       m_tdata,   // bank_group[1:0], bank[3:2],
                                                           // partner_group[5:4], zero[7:6]
    output logic                                m_tlast,
    output logic                                m_tuser    // cmd_kind
);
    import dbrs_pkg::*;

    logic      push;
    slot_rec_t push_rec;
    logic      q_full;
    logic      pop;
    slot_rec_t pop_rec;
    logic      q_empty;

    // Front: slot timing and classification.
    dbrs_front #(
        .BANK_COUNT      (BANK_COUNT),
        .REDUCED_DIVISOR (REDUCED_DIVISOR)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_rec  (push_rec),
        .q_full    (q_full)
    );

    // Slot queue.
    dbrs_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .empty    (q_empty)
    );

    // Back: command expansion.
    dbrs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_rec    (pop_rec),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the dual-bank refresh scheduler: directed and random cycle beats,
// a cycle-level model of the slot schedule and a beat-by-beat check of the command stream.
// Depends on rtl/dbrs_pkg.sv and rtl/dual_bank_refresh_scheduler.sv.
module tb_top;
    import dbrs_pkg::*;

    localparam int BANK_COUNT      = 4;
    localparam int REDUCED_DIVISOR = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_REPORTS     = 10;
    localparam int PHASE_ITEMS     = 50;

    // One command beat as the model expects it.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [1:0] grp;
        logic [1:0] bnk;
        logic [1:0] partner;
        logic       ends_run;
    } refresh_cmd_t;

    // Receiver stall styles.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_SPARSE,
        RX_PATTERN,
        RX_COIN
    } rx_mode_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_addr  = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;   // now[47:0], bank_open[63:48]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;          // bank_group[1:0], bank[3:2],
                                             // partner_group[5:4], zero[7:6]
    logic                  m_tlast;
    logic                  m_tuser;          // cmd_kind

    // Model state: registers, due time, round-robin, turn counter and pair flags.
    logic [1:0]   red_bank_q = 2'd0;
    logic [15:0]  interval_q = 16'd1;
    logic [47:0]  due_at     = 48'd1;
    int           rr_bank    = 0;
    int           red_turn   = 0;
    logic [3:0]   pair_sel   = '0;
    refresh_cmd_t cmd_q[$];
    int           err_count  = 0;

    // Stimulus state.
    int           tx_interval = 1;
    logic [47:0]  cursor      = '0;
    int           burst_left  = 0;
    bit           gaps_on     = 1'b1;
    logic [6:0]   rx_phase    = '0;
    rx_mode_t     rx_mode     = RX_OPEN;

    dual_bank_refresh_scheduler #(
        .BANK_COUNT      (BANK_COUNT),
        .REDUCED_DIVISOR (REDUCED_DIVISOR)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #1 clk = ~clk;

    function automatic refresh_cmd_t cmd_beat(input cmd_kind_t kind, input int grp,
                                              input logic [1:0] bnk, input int partner);
        refresh_cmd_t c;
        c.kind     = kind;
        c.grp      = 2'(grp);
        c.bnk      = bnk;
        c.partner  = 2'(partner);
        c.ends_run = (kind == CMD_REFRESH);
        return c;
    endfunction

    // Serve at most one slot per cycle beat and queue the commands it produces.
    task automatic plan_refresh_slot(input logic [47:0] t, input logic [15:0] open_mask);
        int         ba;
        int         lo;
        logic [1:0] b2;
        bit         issue;
        if (t >= due_at) begin
            due_at  = due_at + 48'(interval_q);
            ba      = rr_bank;
            rr_bank = (rr_bank + 1) % BANK_COUNT;
            issue   = 1'b1;
            // The reduced bank is refreshed only on the first of its turns.
            if (ba == int'(red_bank_q)) begin
                issue    = (red_turn == 0);
                red_turn = (red_turn + 1) % REDUCED_DIVISOR;
            end
            if (issue) begin
                b2 = 2'(ba);
                lo = pair_sel[b2] ? 2 : 0;
                if (open_mask[lo * 4 + b2])
                    cmd_q.push_back(cmd_beat(CMD_PRECHARGE, lo, b2, 0));
                if (open_mask[(lo + 1) * 4 + b2])
                    cmd_q.push_back(cmd_beat(CMD_PRECHARGE, lo + 1, b2, 0));
                cmd_q.push_back(cmd_beat(CMD_REFRESH, lo, b2, lo + 1));
                pair_sel[b2] = ~pair_sel[b2];
            end
        end
    endtask

    // Check each accepted result beat, then track register writes and accepted input beats.
    always @(posedge clk) begin : monitor
        refresh_cmd_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (cmd_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("unexpected beat: kind %0d data %h last %0d",
                                 m_tuser, m_tdata, m_tlast);
                end else begin
                    want = cmd_q.pop_front();
                    if (m_tuser !== want.kind || m_tdata[1:0] !== want.grp ||
                        m_tdata[3:2] !== want.bnk || m_tdata[5:4] !== want.partner ||
                        m_tdata[7:6] !== 2'b00 || m_tlast !== want.ends_run) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $display("mismatch: expected kind %0d group %0d bank %0d partner %0d last %0d",
                                     want.kind, want.grp, want.bnk, want.partner,
                                     want.ends_run);
                            $display("          got kind %0d data %h last %0d",
                                     m_tuser, m_tdata, m_tlast);
                        end
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_addr == CFG_REDUCED_BANK) begin
                    red_bank_q = cfg_wdata[1:0];
                end else begin
                    interval_q = (cfg_wdata == '0) ? 16'd1 : cfg_wdata[15:0];
                    due_at     = 48'(interval_q);
                end
            end
            if (s_tvalid && s_tready)
                plan_refresh_slot(s_tdata[47:0], s_tdata[63:48]);
        end
    end

    // Receiver: a new stall style is drawn at random each time the phase counter wraps.
    always @(posedge clk) begin
        rx_phase <= rx_phase + 7'd1;
        if (rx_phase == 7'd0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:    m_tready <= 1'b1;
            RX_SPARSE:  m_tready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: m_tready <= (rx_phase[2:0] < 3'd3);
            default:    m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Offer one input beat and return at the edge that accepts it; some bursts end in random gaps.
    task automatic send_beat(input logic [47:0] t, input logic [15:0] open_mask);
        int gap;
        s_tdata  <= {open_mask, t};
        s_tvalid <= 1'b1;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0)
                gaps_on = ~gaps_on;
            if (gaps_on) begin
                gap = $urandom_range(1, 4);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop sending and wait until every expected beat has come and the pipeline is empty.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (cmd_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_SLOT_INTERVAL) begin
            tx_interval = (value == '0) ? 1 : int'(value);
            cursor      = '0;
        end
    endtask

    // Mostly a rising cycle count that crosses due times at random; some beats are noise.
    task automatic run_traffic(input int count);
        logic [63:0] wide;
        logic [47:0] t;
        logic [15:0] open_mask;
        for (int i = 0; i < count; i++) begin
            open_mask = 16'($urandom);
            if ($urandom_range(0, 3) == 0)
                open_mask = 16'hFFFF;
            if ($urandom_range(0, 9) == 0) begin
                wide = {$urandom, $urandom};
                t    = wide[47:0];
            end else begin
                cursor = cursor + 48'($urandom_range(0, 2 * tx_interval));
                t      = cursor;
            end
            send_beat(t, open_mask);
        end
    endtask

    // Reset settings: each slot per cycle, open masks of every shape, a late count and extremes.
    task automatic test_directed();
        send_beat(48'd0, 16'hFFFF);
        send_beat(48'd1, 16'hFFFF);
        send_beat(48'd2, 16'h0000);
        send_beat(48'd3, 16'h0040);
        send_beat(48'd4, 16'h0008);
        send_beat(48'd5, 16'hFFFF);
        send_beat(48'd6, 16'hFFFF);
        for (int t = 7; t < 15; t++)
            send_beat(48'(t), (t % 2 == 0) ? 16'hFFFF : 16'h0000);
        // A count far ahead of the due time serves one missed slot per beat.
        repeat (3) send_beat(48'hFFFF_FFFF_FFFF, 16'hFFFF);
        send_beat(48'd0, 16'hAAAA);
        send_beat(48'h8000_0000_0000, 16'h5555);
    endtask

    // A zero interval acts as one; the top bank address becomes the reduced one.
    task automatic test_zero_interval();
        quiesce();
        write_reg(CFG_SLOT_INTERVAL, '0);
        write_reg(CFG_REDUCED_BANK, CFG_DATA_W'(3));
        for (int t = 0; t < 6; t++)
            send_beat(48'(t), 16'hFFFF);
    endtask

    // Random traffic under several settings, the extreme intervals among them.
    task automatic test_settings_sweep();
        logic [15:0] ivl;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       ivl = 16'd2;
                1:       ivl = 16'hFFFF;
                2:       ivl = 16'd7;
                3:       ivl = 16'd1;
                default: ivl = 16'($urandom_range(1, 300));
            endcase
            quiesce();
            write_reg(CFG_REDUCED_BANK,
                      CFG_DATA_W'((p < 4) ? 2'(p + 1) : 2'($urandom_range(0, 3))));
            write_reg(CFG_SLOT_INTERVAL, ivl);
            run_traffic(PHASE_ITEMS);
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_zero_interval();
        test_settings_sweep();
        quiesce();
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #200000;
        $display("tb: failure");
        $finish;
    end

endmodule
